[rtl/cdma_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdma_pkg
// shared types, constants and helpers of the complex double multiply-accumulate
// ----------------------------------------------------------------------------
package cdma_pkg;

    // register stages of one fused multiply-add and of the whole unit
    localparam int FMA_STAGES  = 11;
    localparam int PIPE_STAGES = 2 * FMA_STAGES;

    // operation codes
    localparam logic OP_MUL = 1'b0;
    localparam logic OP_MAC = 1'b1;

    // binary64 encodings
    localparam logic [63:0] SIGN_BIT    = 64'h8000_0000_0000_0000;
    localparam logic [63:0] QUIET_BIT   = 64'h0008_0000_0000_0000;
    localparam logic [63:0] DEFAULT_NAN = 64'hFFF8_0000_0000_0000;
    localparam logic [10:0] EXP_ONES    = 11'h7FF;

    typedef logic signed [13:0] exp_t;

    localparam exp_t EXP_BIAS = 14'sd1075;
    localparam exp_t MIN_LSB  = -14'sd1074;
    localparam exp_t MAX_LSB  = 14'sd971;

    typedef struct packed {
        logic        operation;
        logic [63:0] a_re;
        logic [63:0] a_im;
        logic [63:0] b_re;
        logic [63:0] b_im;
        logic [63:0] acc_re;
        logic [63:0] acc_im;
        logic        last_in;
    } cdma_in_t;

    typedef struct packed {
        logic [63:0] res_re;
        logic [63:0] res_im;
        logic        last_out;
    } cdma_out_t;

    // early-resolved result (nan, infinity, zero operand)
    typedef struct packed {
        logic        spec;
        logic [63:0] val;
    } cdma_spec_t;

    // position of the highest set bit, 0 when none
    function automatic logic [6:0] top_bit(input logic [127:0] x);
        logic [6:0] pos;
        pos = '0;
        for (int i = 0; i < 128; i++)
        begin
            if (x[i])
            begin
                pos = 7'(i);
            end
        end
        return pos;
    endfunction

endpackage

[rtl/cdma_stream_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdma_stream_if
// valid/ready channel carrying one item per handshake
// ----------------------------------------------------------------------------
interface cdma_stream_if #(
    parameter type item_t = logic
);
    logic  valid;
    logic  ready;
    item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[rtl/cdma_fma.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdma_fma
// pipelined binary64 fused multiply-add, a*b + c or a*b - c, round to nearest even
// ----------------------------------------------------------------------------
module cdma_fma import cdma_pkg::*; (
    input  logic                  clk,
    input  logic [FMA_STAGES-1:0] en,
    input  logic [63:0]           a,
    input  logic [63:0]           b,
    input  logic [63:0]           c,
    input  logic                  negc,
    output logic [63:0]           res
);

    // stage 0: classify and unpack
    logic a_nan, b_nan, c_nan, a_inf, b_inf, c_inf, a_zero, b_zero, c_zero;
    logic sp, sc;
    cdma_spec_t spec0;

    assign a_nan  = (a[62:52] == EXP_ONES) && (a[51:0] != '0);
    assign b_nan  = (b[62:52] == EXP_ONES) && (b[51:0] != '0);
    assign c_nan  = (c[62:52] == EXP_ONES) && (c[51:0] != '0);
    assign a_inf  = (a[62:52] == EXP_ONES) && (a[51:0] == '0);
    assign b_inf  = (b[62:52] == EXP_ONES) && (b[51:0] == '0);
    assign c_inf  = (c[62:52] == EXP_ONES) && (c[51:0] == '0);
    assign a_zero = (a[62:0] == '0);
    assign b_zero = (b[62:0] == '0);
    assign c_zero = (c[62:0] == '0);
    assign sp     = a[63] ^ b[63];
    assign sc     = c[63] ^ negc;

    always_comb
    begin
        spec0.spec = 1'b1;
        spec0.val  = '0;
        if (a_nan)
        begin
            spec0.val = a | QUIET_BIT;
        end
        else if (b_nan)
        begin
            spec0.val = b | QUIET_BIT;
        end
        else if (c_nan)
        begin
            spec0.val = c | QUIET_BIT;
        end
        else if (a_inf || b_inf)
        begin
            if (a_zero || b_zero)
            begin
                spec0.val = DEFAULT_NAN;
            end
            else if (c_inf && (sc != sp))
            begin
                spec0.val = DEFAULT_NAN;
            end
            else
            begin
                spec0.val = {sp, EXP_ONES, 52'b0};
            end
        end
        else if (c_inf)
        begin
            spec0.val = {sc, EXP_ONES, 52'b0};
        end
        else if (a_zero || b_zero)
        begin
            spec0.val = c_zero ? {sp & sc, 63'b0} : {sc, c[62:0]};
        end
        else
        begin
            spec0.spec = 1'b0;
        end
    end

    cdma_spec_t  spec_reg [FMA_STAGES-1];
    logic [52:0] s0_ma_reg, s0_mb_reg, s0_mc_reg;
    logic [10:0] s0_ea_reg, s0_eb_reg, s0_ec_reg;
    logic        s0_sp_reg, s0_sc_reg, s0_cz_reg;

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            spec_reg[0] <= spec0;
            s0_ma_reg   <= {a[62:52] != '0, a[51:0]};
            s0_mb_reg   <= {b[62:52] != '0, b[51:0]};
            s0_mc_reg   <= {c[62:52] != '0, c[51:0]};
            s0_ea_reg   <= (a[62:52] == '0) ? 11'd1 : a[62:52];
            s0_eb_reg   <= (b[62:52] == '0) ? 11'd1 : b[62:52];
            s0_ec_reg   <= (c[62:52] == '0) ? 11'd1 : c[62:52];
            s0_sp_reg   <= sp;
            s0_sc_reg   <= sc;
            s0_cz_reg   <= c_zero;
        end
    end

    // special result travels alongside the datapath
    for (genvar k = 1; k < FMA_STAGES - 1; k++)
    begin : g_spec
        always_ff @(posedge clk)
        begin
            if (en[k])
            begin
                spec_reg[k] <= spec_reg[k-1];
            end
        end
    end

    // stage 1: normalize subnormal mantissas
    logic [5:0]  sh_a, sh_b, sh_c;
    logic [52:0] s1_ma_reg, s1_mb_reg, s1_mc_reg;
    exp_t        s1_ea_reg, s1_eb_reg, s1_ec_reg;
    logic        s1_sp_reg, s1_sc_reg, s1_cz_reg;

    assign sh_a = 6'(7'd52 - top_bit({75'b0, s0_ma_reg}));
    assign sh_b = 6'(7'd52 - top_bit({75'b0, s0_mb_reg}));
    assign sh_c = 6'(7'd52 - top_bit({75'b0, s0_mc_reg}));

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            s1_ma_reg <= s0_ma_reg << sh_a;
            s1_mb_reg <= s0_mb_reg << sh_b;
            s1_mc_reg <= s0_mc_reg << sh_c;
            s1_ea_reg <= exp_t'({3'b0, s0_ea_reg}) - EXP_BIAS - exp_t'({8'b0, sh_a});
            s1_eb_reg <= exp_t'({3'b0, s0_eb_reg}) - EXP_BIAS - exp_t'({8'b0, sh_b});
            s1_ec_reg <= exp_t'({3'b0, s0_ec_reg}) - EXP_BIAS - exp_t'({8'b0, sh_c});
            s1_sp_reg <= s0_sp_reg;
            s1_sc_reg <= s0_sc_reg;
            s1_cz_reg <= s0_cz_reg;
        end
    end

    // stage 2: four partial products of at most 27x27 bits
    logic [53:0]  s2_pp00_reg;
    logic [52:0]  s2_pp01_reg, s2_pp10_reg;
    logic [51:0]  s2_pp11_reg;
    logic [52:0]  s2_mc_reg;
    exp_t         s2_ep_reg, s2_ec_reg;
    logic         s2_sp_reg, s2_sc_reg, s2_cz_reg;

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            s2_pp00_reg <= 54'(s1_ma_reg[26:0]) * 54'(s1_mb_reg[26:0]);
            s2_pp01_reg <= 53'(s1_ma_reg[26:0]) * 53'(s1_mb_reg[52:27]);
            s2_pp10_reg <= 53'(s1_ma_reg[52:27]) * 53'(s1_mb_reg[26:0]);
            s2_pp11_reg <= 52'(s1_ma_reg[52:27]) * 52'(s1_mb_reg[52:27]);
            s2_mc_reg   <= s1_mc_reg;
            s2_ep_reg   <= s1_ea_reg + s1_eb_reg;
            s2_ec_reg   <= s1_ec_reg - 14'sd73;
            s2_sp_reg   <= s1_sp_reg;
            s2_sc_reg   <= s1_sc_reg;
            s2_cz_reg   <= s1_cz_reg;
        end
    end

    // stage 3: sum partial products
    logic [105:0] s3_p_reg;
    logic [52:0]  s3_mc_reg;
    exp_t         s3_ep_reg, s3_ec_reg;
    logic         s3_sp_reg, s3_sc_reg, s3_cz_reg;

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            s3_p_reg  <= 106'(s2_pp00_reg) + (106'(s2_pp01_reg) << 27)
                       + (106'(s2_pp10_reg) << 27) + (106'(s2_pp11_reg) << 54);
            s3_mc_reg <= s2_mc_reg;
            s3_ep_reg <= s2_ep_reg;
            s3_ec_reg <= s2_ec_reg;
            s3_sp_reg <= s2_sp_reg;
            s3_sc_reg <= s2_sc_reg;
            s3_cz_reg <= s2_cz_reg;
        end
    end

    // stage 4: both terms to 128 bits with the leading one at bit 125
    logic [127:0] s4_pw_reg, s4_cw_reg;
    exp_t         s4_ep_reg, s4_ec_reg;
    logic         s4_sp_reg, s4_sc_reg, s4_cz_reg;

    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            if (s3_p_reg[105])
            begin
                s4_pw_reg <= {2'b0, s3_p_reg, 20'b0};
                s4_ep_reg <= s3_ep_reg - 14'sd20;
            end
            else
            begin
                s4_pw_reg <= {1'b0, s3_p_reg, 21'b0};
                s4_ep_reg <= s3_ep_reg - 14'sd21;
            end
            s4_cw_reg <= {2'b0, s3_mc_reg, 73'b0};
            s4_ec_reg <= s3_ec_reg;
            s4_sp_reg <= s3_sp_reg;
            s4_sc_reg <= s3_sc_reg;
            s4_cz_reg <= s3_cz_reg;
        end
    end

    // stage 5: order by magnitude
    logic         p_first;
    exp_t         diff;
    logic [127:0] s5_big_reg, s5_small_reg;
    logic [7:0]   s5_d_reg;
    exp_t         s5_eg_reg;
    logic         s5_sign_reg, s5_sub_reg;

    assign p_first = s4_cz_reg || (s4_ep_reg > s4_ec_reg)
                  || ((s4_ep_reg == s4_ec_reg) && (s4_pw_reg >= s4_cw_reg));
    assign diff    = p_first ? (s4_ep_reg - s4_ec_reg) : (s4_ec_reg - s4_ep_reg);

    always_ff @(posedge clk)
    begin
        if (en[5])
        begin
            s5_big_reg   <= p_first ? s4_pw_reg : s4_cw_reg;
            s5_small_reg <= s4_cz_reg ? '0 : (p_first ? s4_cw_reg : s4_pw_reg);
            s5_d_reg     <= (diff > 14'sd255) ? 8'd255 : diff[7:0];
            s5_eg_reg    <= p_first ? s4_ep_reg : s4_ec_reg;
            s5_sign_reg  <= p_first ? s4_sp_reg : s4_sc_reg;
            s5_sub_reg   <= !s4_cz_reg && (s4_sp_reg != s4_sc_reg);
        end
    end

    // stage 6: align smaller term, shifted-out bits kept as sticky
    logic         align_sticky;
    logic [127:0] s6_big_reg, s6_small_reg;
    exp_t         s6_eg_reg;
    logic         s6_sign_reg, s6_sub_reg;

    assign align_sticky = |(s5_small_reg & ~({128{1'b1}} << s5_d_reg));

    always_ff @(posedge clk)
    begin
        if (en[6])
        begin
            s6_big_reg   <= s5_big_reg;
            s6_small_reg <= (s5_small_reg >> s5_d_reg) | {127'b0, align_sticky};
            s6_eg_reg    <= s5_eg_reg;
            s6_sign_reg  <= s5_sign_reg;
            s6_sub_reg   <= s5_sub_reg;
        end
    end

    // stage 7: add or subtract
    logic [127:0] sum;
    logic [127:0] s7_r_reg;
    exp_t         s7_eg_reg;
    logic         s7_sign_reg, s7_zero_reg;

    assign sum = s6_sub_reg ? (s6_big_reg - s6_small_reg) : (s6_big_reg + s6_small_reg);

    always_ff @(posedge clk)
    begin
        if (en[7])
        begin
            s7_r_reg    <= sum;
            s7_eg_reg   <= s6_eg_reg;
            s7_sign_reg <= s6_sign_reg;
            s7_zero_reg <= s6_sub_reg && (sum == '0);
        end
    end

    // stage 8: leading one search
    logic [127:0] s8_r_reg;
    logic [6:0]   s8_lead_reg;
    exp_t         s8_eg_reg;
    logic         s8_sign_reg, s8_zero_reg;

    always_ff @(posedge clk)
    begin
        if (en[8])
        begin
            s8_r_reg    <= s7_r_reg;
            s8_lead_reg <= top_bit(s7_r_reg);
            s8_eg_reg   <= s7_eg_reg;
            s8_sign_reg <= s7_sign_reg;
            s8_zero_reg <= s7_zero_reg;
        end
    end

    // stage 9: place 53 result bits, with round and sticky bits below
    exp_t         lsb_raw, lsb_clamp, s_amt, s_m1;
    logic [7:0]   rsh;
    logic [127:0] rshifted;
    logic [6:0]   lsh;
    logic [53:0]  q9;
    logic         rb9, st9;
    logic [53:0]  s9_q_reg;
    logic         s9_rb_reg, s9_st_reg;
    exp_t         s9_lsb_reg;
    logic         s9_sign_reg, s9_zero_reg;

    always_comb
    begin
        lsb_raw   = exp_t'({7'b0, s8_lead_reg}) + s8_eg_reg - 14'sd52;
        lsb_clamp = (lsb_raw < MIN_LSB) ? MIN_LSB : lsb_raw;
        s_amt     = lsb_clamp - s8_eg_reg;
        s_m1      = s_amt - 14'sd1;
        rsh       = (s_m1 > 14'sd255) ? 8'd255 : s_m1[7:0];
        lsh       = 7'(-s_amt);
        rshifted  = s8_r_reg >> rsh;
        if (s_amt <= 14'sd0)
        begin
            q9  = 54'(s8_r_reg << lsh);
            rb9 = 1'b0;
            st9 = 1'b0;
        end
        else
        begin
            q9  = rshifted[54:1];
            rb9 = rshifted[0];
            st9 = |(s8_r_reg & ~({128{1'b1}} << rsh));
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[9])
        begin
            s9_q_reg    <= q9;
            s9_rb_reg   <= rb9;
            s9_st_reg   <= st9;
            s9_lsb_reg  <= lsb_clamp;
            s9_sign_reg <= s8_sign_reg;
            s9_zero_reg <= s8_zero_reg;
        end
    end

    // stage 10: round to nearest even and pack
    logic [53:0] q_round;
    logic [52:0] q_fin;
    exp_t        lsb_fin;
    logic [10:0] ebits;
    logic [63:0] packed_val;
    logic [63:0] res_next;
    logic [63:0] res_reg;

    always_comb
    begin
        q_round = s9_q_reg + 54'(s9_rb_reg && (s9_st_reg || s9_q_reg[0]));
        if (q_round[53])
        begin
            q_fin   = q_round[53:1];
            lsb_fin = s9_lsb_reg + 14'sd1;
        end
        else
        begin
            q_fin   = q_round[52:0];
            lsb_fin = s9_lsb_reg;
        end
        ebits      = 11'(lsb_fin + 14'sd1074);
        packed_val = {s9_sign_reg, (63'(ebits) << 52) + 63'(q_fin)};
        if (spec_reg[FMA_STAGES-2].spec)
        begin
            res_next = spec_reg[FMA_STAGES-2].val;
        end
        else if (s9_zero_reg)
        begin
            res_next = '0;
        end
        else if (lsb_fin > MAX_LSB)
        begin
            res_next = {s9_sign_reg, EXP_ONES, 52'b0};
        end
        else
        begin
            res_next = packed_val;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[10])
        begin
            res_reg <= res_next;
        end
    end

    assign res = res_reg;

endmodule

[rtl/complex_double_mul_accumulate_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// complex_double_mul_accumulate_unit
// streaming binary64 complex multiply and multiply-accumulate
// ----------------------------------------------------------------------------
// Takes one item per cycle while the output side is not stalled and returns
// one result per item, in order. The unit is two layers of two 11-stage
// fused multiply-add pipelines; the 53x53 mantissa product is split into
// four partial products of at most 27x27 bits in one stage and summed in the
// next, and that split together with the alignment, leading-one and rounding
// stages sets the depth. Multiply (operation 0) gives
// re = a_re*b_re - round(a_im*b_im), im = a_im*b_re + round(a_re*b_im);
// accumulate (operation 1) gives re = a_re*b_re - (a_im*b_im - acc_re) and
// im = a_im*b_re + (a_re*b_im + acc_im), every fused step rounded once to
// nearest even with subnormals kept. last_in is passed through as last_out.
// Each stage advances when it is empty or the stage after it advances, so
// bubbles close up and items are taken while a result waits, until full.
// ----------------------------------------------------------------------------
module complex_double_mul_accumulate_unit import cdma_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    cdma_stream_if.sink   item,
    cdma_stream_if.source result
);

    // per-stage valid bits and advance enables
    logic [PIPE_STAGES-1:0] vld_reg;
    logic [PIPE_STAGES-1:0] vld_next;
    logic [PIPE_STAGES-1:0] en;

    assign en[PIPE_STAGES-1] = !vld_reg[PIPE_STAGES-1] || result.ready;
    for (genvar k = 0; k < PIPE_STAGES - 1; k++)
    begin : g_en
        assign en[k] = !vld_reg[k] || en[k+1];
    end

    assign vld_next[0] = en[0] ? item.valid : vld_reg[0];
    for (genvar k = 1; k < PIPE_STAGES; k++)
    begin : g_vld
        assign vld_next[k] = en[k] ? vld_reg[k-1] : vld_reg[k];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    assign item.ready = en[0];

    // first layer: u and v terms
    logic [63:0] c_u, c_v, u_res, v_res;

    assign c_u = (item.data.operation == OP_MAC) ? item.data.acc_re : SIGN_BIT;
    assign c_v = (item.data.operation == OP_MAC) ? item.data.acc_im : SIGN_BIT;

    cdma_fma u_fma_u (
        .clk  (clk),
        .en   (en[FMA_STAGES-1:0]),
        .a    (item.data.a_im),
        .b    (item.data.b_im),
        .c    (c_u),
        .negc (item.data.operation == OP_MAC),
        .res  (u_res)
    );

    cdma_fma u_fma_v (
        .clk  (clk),
        .en   (en[FMA_STAGES-1:0]),
        .a    (item.data.a_re),
        .b    (item.data.b_im),
        .c    (c_v),
        .negc (1'b0),
        .res  (v_res)
    );

    // operands needed by the second layer ride along the first
    typedef struct packed {
        logic [63:0] a_re;
        logic [63:0] a_im;
        logic [63:0] b_re;
        logic        last;
    } side_t;

    side_t side_reg [FMA_STAGES];
    logic  last_reg [FMA_STAGES];

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            side_reg[0] <= '{a_re: item.data.a_re, a_im: item.data.a_im,
                             b_re: item.data.b_re, last: item.data.last_in};
        end
        if (en[FMA_STAGES])
        begin
            last_reg[0] <= side_reg[FMA_STAGES-1].last;
        end
    end

    for (genvar k = 1; k < FMA_STAGES; k++)
    begin : g_side
        always_ff @(posedge clk)
        begin
            if (en[k])
            begin
                side_reg[k] <= side_reg[k-1];
            end
            if (en[FMA_STAGES+k])
            begin
                last_reg[k] <= last_reg[k-1];
            end
        end
    end

    // second layer: real and imaginary results
    logic [63:0] re_res, im_res;

    cdma_fma u_fma_re (
        .clk  (clk),
        .en   (en[PIPE_STAGES-1:FMA_STAGES]),
        .a    (side_reg[FMA_STAGES-1].a_re),
        .b    (side_reg[FMA_STAGES-1].b_re),
        .c    (u_res),
        .negc (1'b1),
        .res  (re_res)
    );

    cdma_fma u_fma_im (
        .clk  (clk),
        .en   (en[PIPE_STAGES-1:FMA_STAGES]),
        .a    (side_reg[FMA_STAGES-1].a_im),
        .b    (side_reg[FMA_STAGES-1].b_re),
        .c    (v_res),
        .negc (1'b0),
        .res  (im_res)
    );

    // last stage of the second layer is the output register
    assign result.valid         = vld_reg[PIPE_STAGES-1];
    assign result.data.res_re   = re_res;
    assign result.data.res_im   = im_res;
    assign result.data.last_out = last_reg[FMA_STAGES-1];

`ifndef SYNTH
    // a full pipeline with a stalled output cannot take an item
    a_full_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (&vld_reg) && !result.ready |-> !item.ready)
        else $error("item taken into a full stalled pipeline");

    // an accepted item occupies the first stage
    a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
        item.valid && item.ready |=> vld_reg[0])
        else $error("accepted item missing from first stage");

    // a stalled stage keeps its item
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[FMA_STAGES-1] && !en[FMA_STAGES] |=> vld_reg[FMA_STAGES-1])
        else $error("item dropped between layers");

    // an empty first stage always takes an item
    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !vld_reg[0] |-> item.ready)
        else $error("empty first stage refused an item");
`endif

endmodule

[tb/sv/cdma_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdma_checker
// watches both channels, predicts each result with exact integer arithmetic
// and compares it with what the unit returns, in order
// ----------------------------------------------------------------------------
module cdma_checker import cdma_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  logic      in_ready,
    input  cdma_in_t  in_data,
    input  logic      out_valid,
    input  logic      out_ready,
    input  cdma_out_t out_data,
    output int        fail_count,
    output int        outstanding
);

    cdma_out_t awaited_results[$];

    function automatic int msb128(input logic [127:0] x);
        int pos;
        pos = -1;
        for (int i = 0; i < 128; i++)
        begin
            if (x[i])
            begin
                pos = i;
            end
        end
        return pos;
    endfunction

    function automatic void split_double(input logic [63:0] x, output logic [127:0] m,
                                         output int e);
        int sh;
        if (x[62:52] == 0)
        begin
            m = {76'b0, x[51:0]};
            e = -1074;
        end
        else
        begin
            m = {75'b0, 1'b1, x[51:0]};
            e = int'(x[62:52]) - 1075;
        end
        sh = 52 - msb128(m);
        m = m << sh;
        e = e - sh;
    endfunction

    // round sign * r * 2^e to nearest even
    function automatic logic [63:0] round_to_double(input logic [63:0] sign,
                                                    input logic [127:0] r, input int e);
        int lsb;
        int s;
        logic [127:0] shifted;
        logic [63:0] q;
        logic rb;
        logic st;
        lsb = msb128(r) + e - 52;
        if (lsb < -1074)
        begin
            lsb = -1074;
        end
        s = lsb - e;
        if (s <= 0)
        begin
            shifted = r << (-s);
            q = shifted[63:0];
        end
        else
        begin
            rb = (s - 1 < 128) ? r[s - 1] : 1'b0;
            st = (r & ((128'b1 << (s - 1)) - 1)) != 0;
            shifted = r >> s;
            q = (s < 128) ? shifted[63:0] : 64'b0;
            if (rb && (st || q[0]))
            begin
                q = q + 1;
            end
            if (q[53])
            begin
                q = q >> 1;
                lsb = lsb + 1;
            end
        end
        if (lsb > 971)
        begin
            return sign | {1'b0, EXP_ONES, 52'b0};
        end
        return sign | ((64'(lsb + 1074) << 52) + q);
    endfunction

    // a*b + c, or a*b - c when negate_c, rounded once
    function automatic logic [63:0] fused_madd(input logic [63:0] a, input logic [63:0] b,
                                               input logic [63:0] c, input logic negate_c);
        logic [63:0] sp;
        logic [63:0] sc;
        logic [63:0] sbig;
        logic [63:0] ssmall;
        logic [127:0] ma;
        logic [127:0] mb;
        logic [127:0] mc;
        logic [127:0] p;
        logic [127:0] big;
        logic [127:0] lesser;
        logic [127:0] r;
        logic sticky;
        int ea;
        int eb;
        int ec;
        int ep;
        int eg;
        int d;
        int sh;
        logic a_nan, b_nan, c_nan, a_inf, b_inf, c_inf, a_zero, b_zero, c_zero;
        sp = (a ^ b) & SIGN_BIT;
        sc = (c & SIGN_BIT) ^ (negate_c ? SIGN_BIT : 64'b0);
        a_nan = a[62:52] == EXP_ONES && a[51:0] != 0;
        b_nan = b[62:52] == EXP_ONES && b[51:0] != 0;
        c_nan = c[62:52] == EXP_ONES && c[51:0] != 0;
        a_inf = a[62:52] == EXP_ONES && a[51:0] == 0;
        b_inf = b[62:52] == EXP_ONES && b[51:0] == 0;
        c_inf = c[62:52] == EXP_ONES && c[51:0] == 0;
        a_zero = a[62:0] == 0;
        b_zero = b[62:0] == 0;
        c_zero = c[62:0] == 0;
        if (a_nan) return a | QUIET_BIT;
        if (b_nan) return b | QUIET_BIT;
        if (c_nan) return c | QUIET_BIT;
        if (a_inf || b_inf)
        begin
            if (a_zero || b_zero) return DEFAULT_NAN;
            if (c_inf && sc != sp) return DEFAULT_NAN;
            return sp | {1'b0, EXP_ONES, 52'b0};
        end
        if (c_inf) return sc | {1'b0, EXP_ONES, 52'b0};
        if (a_zero || b_zero)
        begin
            if (c_zero) return sp & sc;
            return sc | (c & ~SIGN_BIT);
        end
        split_double(a, ma, ea);
        split_double(b, mb, eb);
        p = ma * mb;
        sh = 125 - msb128(p);
        p = p << sh;
        ep = ea + eb - sh;
        if (c_zero) return round_to_double(sp, p, ep);
        split_double(c, mc, ec);
        mc = mc << 73;
        ec = ec - 73;
        if (ep > ec || (ep == ec && p >= mc))
        begin
            big = p; sbig = sp; eg = ep; lesser = mc; ssmall = sc; d = ep - ec;
        end
        else
        begin
            big = mc; sbig = sc; eg = ec; lesser = p; ssmall = sp; d = ec - ep;
        end
        if (d > 0)
        begin
            sticky = (lesser & ((128'b1 << d) - 1)) != 0;
            lesser = (lesser >> d) | {127'b0, sticky};
        end
        if (sbig == ssmall)
        begin
            r = big + lesser;
        end
        else
        begin
            r = big - lesser;
            if (r == 0) return 64'b0;
        end
        return round_to_double(sbig, r, eg);
    endfunction

    function automatic cdma_out_t complex_product(input cdma_in_t x);
        cdma_out_t y;
        logic [63:0] t1;
        logic [63:0] t2;
        if (x.operation == OP_MUL)
        begin
            t1 = fused_madd(x.a_im, x.b_im, SIGN_BIT, 1'b0);
            t2 = fused_madd(x.a_re, x.b_im, SIGN_BIT, 1'b0);
        end
        else
        begin
            t1 = fused_madd(x.a_im, x.b_im, x.acc_re, 1'b1);
            t2 = fused_madd(x.a_re, x.b_im, x.acc_im, 1'b0);
        end
        y.res_re = fused_madd(x.a_re, x.b_re, t1, 1'b1);
        y.res_im = fused_madd(x.a_im, x.b_re, t2, 1'b0);
        y.last_out = x.last_in;
        return y;
    endfunction

    assign outstanding = awaited_results.size();

    always @(posedge clk or negedge rst_n)
    begin
        cdma_out_t want;
        if (!rst_n)
        begin
            fail_count <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                awaited_results.push_back(complex_product(in_data));
            end
            if (out_valid && out_ready)
            begin
                if (awaited_results.size() == 0)
                begin
                    $error("unexpected result item %h", out_data);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = awaited_results.pop_front();
                    if (out_data.res_re !== want.res_re)
                    begin
                        $error("res_re expected %h got %h", want.res_re, out_data.res_re);
                    end
                    if (out_data.res_im !== want.res_im)
                    begin
                        $error("res_im expected %h got %h", want.res_im, out_data.res_im);
                    end
                    if (out_data.last_out !== want.last_out)
                    begin
                        $error("last_out expected %b got %b", want.last_out,
                               out_data.last_out);
                    end
                    if (out_data !== want)
                    begin
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// drives directed and random complex items into the unit with random gaps
// and output stalls; a checker beside the unit predicts and compares
// ----------------------------------------------------------------------------
module testbench;
    import cdma_pkg::*;

    localparam int RANDOM_ITEMS = 1100;
    localparam int CYCLE_LIMIT  = 900000;
    localparam int DRAIN_CYCLES = 2 * PIPE_STAGES;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   outstanding;
    int   cycle_count;
    int   stall_left;

    cdma_stream_if #(.item_t(cdma_in_t))  item_if ();
    cdma_stream_if #(.item_t(cdma_out_t)) result_if ();

    complex_double_mul_accumulate_unit uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_if),
        .result (result_if)
    );

    cdma_checker checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (item_if.valid),
        .in_ready    (item_if.ready),
        .in_data     (item_if.data),
        .out_valid   (result_if.valid),
        .out_ready   (result_if.ready),
        .out_data    (result_if.data),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    // 12 ns clock
    initial clk = 1'b0;
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("complex_double_mul_accumulate_unit regression: fail");
            $finish;
        end
    end

    // gap length: mostly none or short, sometimes long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // output back-pressure: random stalls, with stall-free stretches
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_if.ready <= 1'b0;
            stall_left <= 0;
        end
        else if (stall_left > 0)
        begin
            result_if.ready <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if ($urandom_range(0, 3) == 0)
        begin
            result_if.ready <= 1'b0;
            stall_left <= pick_gap();
        end
        else
        begin
            result_if.ready <= 1'b1;
            // occasionally rewrite the stall counter with zero
            if ($urandom_range(0, 49) == 0)
            begin
                stall_left <= 0;
            end
        end
    end

    function automatic logic [63:0] pick_double();
        logic        sign;
        logic [51:0] frac;
        sign = 1'($urandom_range(0, 1));
        frac = 52'({$urandom, $urandom});
        case ($urandom_range(0, 15))
            0:  return {sign, 63'b0};
            1:  return {sign, EXP_ONES, 52'b0};
            2:  return {sign, EXP_ONES, frac | 52'b1};
            3:  return {sign, 11'b0, frac};
            4:  return {sign, 11'($urandom_range(1, 60)), frac};
            5:  return {sign, 11'($urandom_range(1990, 2046)), frac};
            6,
            7:  return {$urandom, $urandom};
            8,
            9:  return ($realtobits($itor($urandom_range(1, 16))) & ~SIGN_BIT) |
                       {sign, 63'b0};
            default: return {sign, 11'($urandom_range(1013, 1033)), frac};
        endcase
    endfunction

    // present one item, keeping valid high when no gap precedes it
    task automatic send_item(input cdma_in_t x, input int gap);
        if (gap > 0)
        begin
            item_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_if.valid <= 1'b1;
        item_if.data  <= x;
        do
        begin
            @(posedge clk);
        end
        while (!item_if.ready);
    endtask

    function automatic cdma_in_t build_item(input logic op, input logic [63:0] ar,
                                            input logic [63:0] ai, input logic [63:0] br,
                                            input logic [63:0] bi, input logic [63:0] cr,
                                            input logic [63:0] ci, input logic last);
        cdma_in_t x;
        x.operation = op;
        x.a_re = ar; x.a_im = ai; x.b_re = br; x.b_im = bi;
        x.acc_re = cr; x.acc_im = ci; x.last_in = last;
        return x;
    endfunction

    initial
    begin
        cdma_in_t     x;
        cdma_in_t     directed_items[$];
        logic [63:0]  one_v;
        logic [63:0]  two_v;
        logic [63:0]  three_v;
        logic [63:0]  inf_v;
        logic [63:0]  snan_v;
        logic [63:0]  max_v;
        logic [63:0]  tiny_v;
        int           burst_left;

        one_v   = $realtobits(1.0);
        two_v   = $realtobits(2.0);
        three_v = $realtobits(3.0);
        inf_v   = {1'b0, EXP_ONES, 52'b0};
        snan_v  = 64'h7FF0_0000_0000_0001;
        max_v   = 64'h7FEF_FFFF_FFFF_FFFF;
        tiny_v  = 64'h0000_0000_0000_0001;

        cycle_count = 0;
        rst_n = 1'b0;
        item_if.valid = 1'b0;
        item_if.data = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // plain products, both operations
        directed_items.push_back(build_item(OP_MUL, one_v, two_v, three_v, one_v,
                                            '0, '0, 1'b0));
        directed_items.push_back(build_item(OP_MAC, one_v, two_v, three_v, one_v,
                                            three_v, two_v, 1'b1));
        // exact cancellation to zero, and minus zero plus minus zero
        directed_items.push_back(build_item(OP_MAC, $realtobits(1.5), $realtobits(1.5),
                                            two_v, two_v, three_v, SIGN_BIT, 1'b0));
        directed_items.push_back(build_item(OP_MAC, SIGN_BIT, SIGN_BIT, one_v, one_v,
                                            '0, SIGN_BIT, 1'b1));
        directed_items.push_back(build_item(OP_MUL, '0, SIGN_BIT, SIGN_BIT, '0,
                                            '0, '0, 1'b0));
        // infinity times zero, opposing infinities
        directed_items.push_back(build_item(OP_MUL, inf_v, '0, one_v, '0,
                                            '0, '0, 1'b0));
        directed_items.push_back(build_item(OP_MAC, inf_v, inf_v, one_v, one_v,
                                            inf_v, inf_v | SIGN_BIT, 1'b1));
        // nan ordering, signaling nans quieted
        directed_items.push_back(build_item(OP_MAC, snan_v, snan_v | SIGN_BIT, one_v,
                                            snan_v | 64'h10, snan_v | 64'h20,
                                            snan_v | 64'h40, 1'b0));
        directed_items.push_back(build_item(OP_MAC, one_v, one_v, one_v, one_v,
                                            snan_v | SIGN_BIT, snan_v, 1'b1));
        // overflow and subnormal underflow
        directed_items.push_back(build_item(OP_MUL, max_v, max_v, max_v, max_v | SIGN_BIT,
                                            '0, '0, 1'b0));
        directed_items.push_back(build_item(OP_MUL, tiny_v, tiny_v, $realtobits(0.5),
                                            tiny_v | SIGN_BIT, '0, '0, 1'b1));
        directed_items.push_back(build_item(OP_MAC, tiny_v, max_v, tiny_v, tiny_v,
                                            tiny_v, max_v, 1'b0));
        // all ones, all zeros, and infinity times zero with infinite accumulators
        directed_items.push_back(build_item(OP_MAC, '1, '1, '1, '1, '1, '1, 1'b1));
        directed_items.push_back(build_item(OP_MUL, '0, '0, '0, '0, '0, '0, 1'b0));
        directed_items.push_back(build_item(OP_MAC, inf_v, one_v, '0, one_v,
                                            inf_v | SIGN_BIT, inf_v, 1'b1));

        foreach (directed_items[i])
        begin
            send_item(directed_items[i], pick_gap());
        end

        burst_left = 0;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (burst_left == 0 && $urandom_range(0, 39) == 0)
            begin
                burst_left = $urandom_range(10, 40);
            end
            x = build_item(1'($urandom_range(0, 1)), pick_double(), pick_double(),
                           pick_double(), pick_double(), pick_double(), pick_double(),
                           1'($urandom_range(0, 3) == 0));
            if (burst_left > 0)
            begin
                burst_left--;
                send_item(x, 0);
            end
            else
            begin
                send_item(x, pick_gap());
            end
        end
        item_if.valid <= 1'b0;

        while (outstanding != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
        begin
            $display("complex_double_mul_accumulate_unit regression: pass");
        end
        else
        begin
            $display("complex_double_mul_accumulate_unit regression: fail");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/cdma_pkg.sv
rtl/cdma_stream_if.sv
rtl/cdma_fma.sv
rtl/complex_double_mul_accumulate_unit.sv
tb/sv/cdma_checker.sv
tb/sv/testbench.sv
